FILE: rtl/deq_pkg.sv
package deq_pkg;

  // Fixed field widths of the transaction ports
  localparam int WORD_W = 32;
  localparam int IDX_W  = 6;
  localparam int LEN_W  = 7;

  // Operation codes carried on the mode field
  localparam logic [2:0] MODE_HEAD_PUSH   = 3'd0;
  localparam logic [2:0] MODE_TAIL_PUSH   = 3'd1;
  localparam logic [2:0] MODE_HEAD_POP    = 3'd2;
  localparam logic [2:0] MODE_TAIL_POP    = 3'd3;
  localparam logic [2:0] MODE_HEAD_INDEX  = 3'd4;
  localparam logic [2:0] MODE_TAIL_INDEX  = 3'd5;
  localparam logic [2:0] MODE_HEAD_REMOVE = 3'd6;
  localparam logic [2:0] MODE_TAIL_REMOVE = 3'd7;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_INDEX,
    OP_REMOVE
  } op_kind_t;

  // Classified operation handed from the front to the back
  typedef struct packed {
    op_kind_t kind;
    logic     from_tail;
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SRD,
    S_SCMP,
    S_SHRD,
    S_SHWR,
    S_DONE
  } back_state_t;

endpackage

FILE: rtl/double_ended_queue.sv
// Bounded double-ended queue of data words kept in a ring store.
// Input channel (in_valid/in_ready): mode picks push, pop, indexed read or
// remove-by-value at the head or tail end; value is the word to push or to
// search for; index is the position counted from the chosen end.
// Output channel (out_valid/out_ready): exactly one transaction per input,
// in order: value_res (word popped, read or removed, else zero), status
// (ok, empty, not found / out of range, full) and length after the op.
// A two-entry queue decouples acceptance from execution, so the input keeps
// accepting while a result waits in the output register.
// Push and a status settled on arrival (full, empty, index out of range)
// are answered straight from the idle state, so the back end stays idle and
// can take the next op while the output is free; pop and indexed read first
// read the store and load the result from its registered read port.
// Remove walks the store element by element (read, then compare), then on a
// match shifts each later element (read, then write) to close the gap, and
// loads its result from the done state.
// Reset empties the queue (head and length cleared); no clearing pass runs.
// A stalled output holds its result and the back end waits; once the input
// queue fills, in_ready drops.
module double_ended_queue #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    mode,
  input  logic [deq_pkg::WORD_W-1:0]    value,
  input  logic [deq_pkg::IDX_W-1:0]     index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [deq_pkg::WORD_W-1:0]    value_res,
  output logic [1:0]                    status,
  output logic [deq_pkg::LEN_W-1:0]     length
);

  logic                        q_valid;
  logic                        q_ready;
  deq_pkg::op_t                q_op;
  logic [DATA_WIDTH-1:0]       q_value;
  logic [deq_pkg::IDX_W-1:0]   q_index;

  deq_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .value    (value),
    .index    (index),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_op     (q_op),
    .q_value  (q_value),
    .q_index  (q_index)
  );

  deq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_op      (q_op),
    .q_value   (q_value),
    .q_index   (q_index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_res (value_res),
    .status    (status),
    .length    (length)
  );

endmodule

FILE: rtl/deq_front.sv
module deq_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    mode,
  input  logic [deq_pkg::WORD_W-1:0]    value,
  input  logic [deq_pkg::IDX_W-1:0]     index,
  output logic                          q_valid,
  input  logic                          q_ready,
  output deq_pkg::op_t                  q_op,
  output logic [DATA_WIDTH-1:0]         q_value,
  output logic [deq_pkg::IDX_W-1:0]     q_index
);

  // Two-entry queue between the front and the back
  deq_pkg::op_t                fq_op  [2];
  logic [DATA_WIDTH-1:0]       fq_val [2];
  logic [deq_pkg::IDX_W-1:0]   fq_idx [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  fill;
  logic [1:0]                  fill_next;

  deq_pkg::op_t                    dec_op;
  logic [DATA_WIDTH+deq_pkg::WORD_W-1:0] val_ext;
  logic                            push;
  logic                            pop;

  // Classify the incoming transaction
  always_comb begin
    dec_op.kind      = deq_pkg::OP_PUSH;
    dec_op.from_tail = 1'b0;
    case (mode)
      deq_pkg::MODE_HEAD_PUSH: begin
        dec_op.kind = deq_pkg::OP_PUSH;   dec_op.from_tail = 1'b0;
      end
      deq_pkg::MODE_TAIL_PUSH: begin
        dec_op.kind = deq_pkg::OP_PUSH;   dec_op.from_tail = 1'b1;
      end
      deq_pkg::MODE_HEAD_POP: begin
        dec_op.kind = deq_pkg::OP_POP;    dec_op.from_tail = 1'b0;
      end
      deq_pkg::MODE_TAIL_POP: begin
        dec_op.kind = deq_pkg::OP_POP;    dec_op.from_tail = 1'b1;
      end
      deq_pkg::MODE_HEAD_INDEX: begin
        dec_op.kind = deq_pkg::OP_INDEX;  dec_op.from_tail = 1'b0;
      end
      deq_pkg::MODE_TAIL_INDEX: begin
        dec_op.kind = deq_pkg::OP_INDEX;  dec_op.from_tail = 1'b1;
      end
      deq_pkg::MODE_HEAD_REMOVE: begin
        dec_op.kind = deq_pkg::OP_REMOVE; dec_op.from_tail = 1'b0;
      end
      deq_pkg::MODE_TAIL_REMOVE: begin
        dec_op.kind = deq_pkg::OP_REMOVE; dec_op.from_tail = 1'b1;
      end
      default: begin
        dec_op.kind = deq_pkg::OP_PUSH;   dec_op.from_tail = 1'b0;
      end
    endcase
  end

  // Fit the data word to the internal width
  assign val_ext = {{DATA_WIDTH{1'b0}}, value};

  assign in_ready  = (fill != 2'd2);
  assign q_valid   = (fill != 2'd0);
  assign q_op      = fq_op[rd_ptr];
  assign q_value   = fq_val[rd_ptr];
  assign q_index   = fq_idx[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = q_valid && q_ready;
  assign fill_next = fill + {1'b0, push} - {1'b0, pop};

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // Hold queued payload
  always_ff @(posedge clk) begin
    if (push) begin
      fq_op[wr_ptr]  <= dec_op;
      fq_val[wr_ptr] <= val_ext[DATA_WIDTH-1:0];
      fq_idx[wr_ptr] <= index;
    end
  end

endmodule

FILE: rtl/deq_back.sv
module deq_back #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  deq_pkg::op_t                  q_op,
  input  logic [DATA_WIDTH-1:0]         q_value,
  input  logic [deq_pkg::IDX_W-1:0]     q_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [deq_pkg::WORD_W-1:0]    value_res,
  output logic [1:0]                    status,
  output logic [deq_pkg::LEN_W-1:0]     length
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + deq_pkg::IDX_W;

  // Ring store
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;

  deq_pkg::back_state_t  state, state_next;
  logic [AW-1:0]         head, head_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         k, k_next;
  logic                  cur_tail, cur_tail_next;
  logic [DATA_WIDTH-1:0] cur_val, cur_val_next;
  logic [DATA_WIDTH-1:0] wsave, wsave_next;
  deq_pkg::status_t      res_status, res_status_next;

  logic                  out_load;
  logic [DATA_WIDTH-1:0] out_word, out_word_next;
  deq_pkg::status_t      out_status, out_status_next;
  logic [CW-1:0]         out_cnt, out_cnt_next;

  logic                  out_free;
  logic                  is_empty;
  logic                  is_full;
  logic [CW-1:0]         cnt_dec;
  logic [CW-1:0]         cnt_inc;
  logic [CW-1:0]         k_inc;
  logic [AW-1:0]         head_dec;
  logic [XW-1:0]         idx_w;
  logic [XW-1:0]         cnt_w;
  logic [XW-1:0]         pos_w;
  logic                  idx_miss;
  logic [CW-1:0]         scan_pos;
  logic                  scan_hit;
  logic                  scan_last;
  logic                  shift_more;
  logic [DATA_WIDTH+deq_pkg::WORD_W-1:0] word_ext;
  logic [CW+deq_pkg::LEN_W-1:0]          len_ext;

  // Ring slot of element k counted from the head
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [AW-1:0] kk);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, kk};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign out_free   = !out_valid || out_ready;
  assign is_empty   = (count == '0);
  assign is_full    = (count == CW'(DEPTH));
  assign cnt_dec    = count - CW'(1);
  assign cnt_inc    = count + CW'(1);
  assign k_inc      = k + CW'(1);
  assign head_dec   = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign idx_w      = {{CW{1'b0}}, q_index};
  assign cnt_w      = {{deq_pkg::IDX_W{1'b0}}, count};
  assign idx_miss   = (idx_w >= cnt_w);
  assign pos_w      = q_op.from_tail ? (cnt_w - XW'(1) - idx_w) : idx_w;
  assign scan_pos   = cur_tail ? (cnt_dec - k) : k;
  assign scan_hit   = (rd_data == cur_val);
  assign scan_last  = (k_inc == count);
  assign shift_more = (k_inc < count);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      deq_pkg::S_IDLE: begin
        if (q_valid && out_free) begin
          case (q_op.kind)
            deq_pkg::OP_POP: begin
              if (!is_empty) begin
                state_next = deq_pkg::S_READ;
              end
            end
            deq_pkg::OP_INDEX: begin
              if (!is_empty && !idx_miss) begin
                state_next = deq_pkg::S_READ;
              end
            end
            deq_pkg::OP_REMOVE: begin
              if (!is_empty) begin
                state_next = deq_pkg::S_SRD;
              end
            end
            default: begin
              state_next = deq_pkg::S_IDLE;
            end
          endcase
        end
      end
      deq_pkg::S_READ: begin
        if (out_free) begin
          state_next = deq_pkg::S_IDLE;
        end
      end
      deq_pkg::S_SRD: begin
        state_next = deq_pkg::S_SCMP;
      end
      deq_pkg::S_SCMP: begin
        if (scan_hit) begin
          state_next = deq_pkg::S_SHRD;
        end else if (scan_last) begin
          state_next = deq_pkg::S_DONE;
        end else begin
          state_next = deq_pkg::S_SRD;
        end
      end
      deq_pkg::S_SHRD: begin
        state_next = shift_more ? deq_pkg::S_SHWR : deq_pkg::S_DONE;
      end
      deq_pkg::S_SHWR: begin
        state_next = deq_pkg::S_SHRD;
      end
      deq_pkg::S_DONE: begin
        if (out_free) begin
          state_next = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = deq_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath controls and register next values
  always_comb begin
    q_ready         = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = head;
    mem_wdata       = rd_data;
    mem_re          = 1'b0;
    mem_raddr       = head;
    head_next       = head;
    count_next      = count;
    k_next          = k;
    cur_tail_next   = cur_tail;
    cur_val_next    = cur_val;
    wsave_next      = wsave;
    res_status_next = res_status;
    out_load        = 1'b0;
    out_word_next   = '0;
    out_status_next = deq_pkg::ST_OK;
    out_cnt_next    = count;
    case (state)
      deq_pkg::S_IDLE: begin
        if (q_valid && out_free) begin
          q_ready       = 1'b1;
          cur_tail_next = q_op.from_tail;
          cur_val_next  = q_value;
          case (q_op.kind)
            deq_pkg::OP_PUSH: begin
              out_load = 1'b1;
              if (is_full) begin
                out_status_next = deq_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = q_value;
                if (q_op.from_tail) begin
                  mem_waddr = slot(head, count[AW-1:0]);
                end else begin
                  mem_waddr = head_dec;
                  head_next = head_dec;
                end
                count_next   = cnt_inc;
                out_cnt_next = cnt_inc;
              end
            end
            deq_pkg::OP_POP: begin
              if (is_empty) begin
                out_load        = 1'b1;
                out_status_next = deq_pkg::ST_EMPTY;
              end else begin
                mem_re = 1'b1;
                if (q_op.from_tail) begin
                  mem_raddr = slot(head, cnt_dec[AW-1:0]);
                end else begin
                  mem_raddr = head;
                  head_next = slot(head, AW'(1));
                end
                count_next = cnt_dec;
              end
            end
            deq_pkg::OP_INDEX: begin
              if (is_empty) begin
                out_load        = 1'b1;
                out_status_next = deq_pkg::ST_EMPTY;
              end else if (idx_miss) begin
                out_load        = 1'b1;
                out_status_next = deq_pkg::ST_MISS;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = slot(head, pos_w[AW-1:0]);
              end
            end
            deq_pkg::OP_REMOVE: begin
              if (is_empty) begin
                out_load        = 1'b1;
                out_status_next = deq_pkg::ST_EMPTY;
              end else begin
                k_next = '0;
              end
            end
            default: begin
              q_ready = 1'b1;
            end
          endcase
        end
      end
      deq_pkg::S_READ: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_word_next = rd_data;
        end
      end
      deq_pkg::S_SRD: begin
        mem_re    = 1'b1;
        mem_raddr = slot(head, scan_pos[AW-1:0]);
      end
      deq_pkg::S_SCMP: begin
        if (scan_hit) begin
          wsave_next      = rd_data;
          k_next          = scan_pos;
          res_status_next = deq_pkg::ST_OK;
        end else if (scan_last) begin
          res_status_next = deq_pkg::ST_MISS;
        end else begin
          k_next = k_inc;
        end
      end
      deq_pkg::S_SHRD: begin
        if (shift_more) begin
          mem_re    = 1'b1;
          mem_raddr = slot(head, k_inc[AW-1:0]);
        end else begin
          count_next = cnt_dec;
        end
      end
      deq_pkg::S_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = slot(head, k[AW-1:0]);
        mem_wdata = rd_data;
        k_next    = k_inc;
      end
      deq_pkg::S_DONE: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_next = res_status;
          out_word_next   = (res_status == deq_pkg::ST_OK) ? wsave : '0;
        end
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
  end

  // Write and read the ring store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= deq_pkg::S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold working and result payload
  always_ff @(posedge clk) begin
    k          <= k_next;
    cur_tail   <= cur_tail_next;
    cur_val    <= cur_val_next;
    wsave      <= wsave_next;
    res_status <= res_status_next;
    if (out_load) begin
      out_word   <= out_word_next;
      out_status <= out_status_next;
      out_cnt    <= out_cnt_next;
    end
  end

  // Fit result fields to port widths
  assign word_ext  = {{deq_pkg::WORD_W{1'b0}}, out_word};
  assign len_ext   = {{deq_pkg::LEN_W{1'b0}}, out_cnt};
  assign value_res = word_ext[deq_pkg::WORD_W-1:0];
  assign status    = out_status;
  assign length    = len_ext[deq_pkg::LEN_W-1:0];

endmodule
